// ===== sv/sspq_pkg.sv =====
// Shared types, sizes and codes for the stable sorted priority queue.
package sspq_pkg;

  // Sizes.
  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 4;
  localparam int VEH_W    = 17;
  localparam int PAS_W    = 3;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Input beat.
  typedef struct packed {
    logic                opcode;
    logic [KEY_BITS-1:0] priority_key;
    logic [VEH_W-1:0]    vehicle_id;
    logic [PAS_W-1:0]    passenger_count;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]          status;
    logic                out_valid;
    logic [KEY_BITS-1:0] out_key;
    logic [VEH_W-1:0]    out_vehicle_id;
    logic [PAS_W-1:0]    out_passenger_count;
    logic [CNT_W-1:0]    entry_count;
  } out_item_t;

  // One stored entry.
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [VEH_W-1:0]    vehicle;
    logic [PAS_W-1:0]    passengers;
  } slot_t;

  // Per-cell control: insert, pop and occupied.
  typedef struct packed {
    logic ins;
    logic pop;
    logic occupied;
  } cell_ctrl_t;

endpackage

// ===== sv/sspq_cell.sv =====
// One cell of the sorted row: holds one entry and shifts it left or right.
module sspq_cell
  import sspq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  slot_t      new_entry,
  input  slot_t      left_entry,
  input  slot_t      right_entry,
  input  logic       left_keep,
  output logic       keep,
  output slot_t      entry_r
);

  slot_t entry_nxt;

  // The entry stays put on insert when it ranks at or above the new key.
  assign keep = ctrl.occupied && (entry_r.key >= new_entry.key);

  // Insert: first cell that does not keep takes the new entry, later cells
  // take their left neighbor. Pop: every cell takes its right neighbor.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (!keep) begin
        entry_nxt = left_keep ? new_entry : left_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== sv/stable_sorted_priority_queue_top.sv =====
// Top level: sorted row of cells, occupancy count and result register.
// The result beat is registered in the cycle after the input beat is accepted.
// Throughput: one insert or pop per cycle while in_ready is high; the cell row
// shifts as a whole, and the result register drains while the next beat enters.
// Reset clears the occupancy count and the result valid; stored entries are
// undefined until written and are never read above the occupancy.
module stable_sorted_priority_queue_top
  import sspq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             fire, is_full, is_empty, do_ins, do_pop;
  slot_t            new_entry;
  slot_t            cell_q [CAPACITY];
  logic             keep   [CAPACITY];

  // Accept a beat whenever the result register is free or being emptied.
  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);
  assign do_ins    = fire && (in_item.opcode == OP_INSERT) && !is_full;
  assign do_pop    = fire && (in_item.opcode == OP_POP) && !is_empty;

  assign new_entry.key        = in_item.priority_key;
  assign new_entry.vehicle    = in_item.vehicle_id;
  assign new_entry.passengers = in_item.passenger_count;

  // Row of cells, head at index zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t ctrl;
    slot_t      left_e;
    slot_t      right_e;
    logic       left_k;

    assign ctrl.ins      = do_ins;
    assign ctrl.pop      = do_pop;
    assign ctrl.occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_e = cell_q[i-1];
      assign left_k = keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    sspq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_keep   (left_k),
      .keep        (keep[i]),
      .entry_r     (cell_q[i])
    );
  end

  // Occupancy and result beat.
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (fire) begin
      out_valid_nxt                    = 1'b1;
      out_item_nxt                     = '0;
      out_item_nxt.entry_count         = count_nxt;
      if (in_item.opcode == OP_INSERT) begin
        out_item_nxt.status = is_full ? ST_FULL : ST_OK;
      end else if (is_empty) begin
        out_item_nxt.status = ST_EMPTY;
      end else begin
        out_item_nxt.status              = ST_OK;
        out_item_nxt.out_valid           = 1'b1;
        out_item_nxt.out_key             = cell_q[0].key;
        out_item_nxt.out_vehicle_id      = cell_q[0].vehicle;
        out_item_nxt.out_passenger_count = cell_q[0].passengers;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The occupancy never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // The head never ranks below the second entry.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_q[0].key >= cell_q[1].key))
    else $error("head entry out of order");

  // An insert into a full queue leaves the count alone and reports full.
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_item.opcode == OP_INSERT) && is_full)
      |=> (count_r == CNT_W'(CAPACITY)) && (out_item_r.status == ST_FULL))
    else $error("full insert not rejected");

  // A pop on an empty queue reports empty and returns no entry.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_item.opcode == OP_POP) && is_empty)
      |=> (out_item_r.status == ST_EMPTY) && !out_item_r.out_valid)
    else $error("empty pop not reported");

  // The reported count always matches the occupancy it leaves behind.
  a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_item_r.entry_count == count_r))
    else $error("reported count mismatch");

endmodule
